// ===== hw/rtl/x86ifd_pkg.sv =====
package x86ifd_pkg;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_OPCODE = 3'd1,
      PH_MODRM  = 3'd2,
      PH_SIB    = 3'd3,
      PH_DISP   = 3'd4,
      PH_IMM    = 3'd5
   } phase_type;

   localparam logic [7:0] REX_MASK      = 8'hF0;
   localparam logic [7:0] REX_PATTERN   = 8'h40;
   localparam logic [7:0] OP_MOV_LOAD   = 8'h8B;
   localparam logic [7:0] OP_MOV_STORE  = 8'h89;
   localparam logic [7:0] OP_ADD_STORE  = 8'h01;
   localparam logic [7:0] OP_IMM_MASK   = 8'hF8;
   localparam logic [7:0] OP_MOV_IMM    = 8'hB8;
   localparam int unsigned REX_W_BIT    = 3;

   localparam logic [1:0] MOD_INDIRECT  = 2'd0;
   localparam logic [1:0] MOD_DISP8     = 2'd1;
   localparam logic [1:0] MOD_DISP32    = 2'd2;
   localparam logic [1:0] MOD_REGISTER  = 2'd3;
   localparam logic [2:0] RM_SIB        = 3'd4;
   localparam logic [2:0] RM_DISP_ONLY  = 3'd5;

   localparam logic [2:0] DISP_NONE     = 3'd0;
   localparam logic [2:0] DISP_SIZE8    = 3'd1;
   localparam logic [2:0] DISP_SIZE32   = 3'd4;
   localparam logic [3:0] IMM_NONE      = 4'd0;
   localparam logic [3:0] IMM_SIZE32    = 4'd4;
   localparam logic [3:0] IMM_SIZE64    = 4'd8;

   typedef struct packed {
      logic [3:0]         inst_length;
      logic [7:0]         rex_byte;
      logic [7:0]         opcode;
      logic [7:0]         modrm_byte;
      logic [7:0]         sib_byte;
      logic signed [31:0] displacement;
      logic [2:0]         disp_bytes;
      logic [63:0]        immediate;
      logic [3:0]         imm_bytes;
   } result_type;

endpackage

// ===== hw/rtl/x86_64_instruction_field_decoder.sv =====
// Splits an x86-64 code byte stream into instructions, one byte per clock
// unless req_stall holds the input. Each byte is registered on entry and from
// that register steps the decode phase machine (REX, opcode, ModRM, SIB,
// disp8/disp32, imm32/imm64); a byte that completes an instruction pushes its
// result into the result buffer, whose output register drives the result beat.
// Sustained rate is one byte per cycle while the buffer is not full, set by
// the per-byte phase update. A two-entry result buffer lets bytes keep flowing
// while a result waits; req_stall rises only when both entries are full and an
// entered byte is pending. Unsupported opcodes end the instruction at the
// opcode byte with ModRM, SIB, displacement and immediate fields zero.
module x86_64_instruction_field_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_code_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_inst_length,
   output logic [7:0]         rsp_rex_byte,
   output logic [7:0]         rsp_opcode,
   output logic [7:0]         rsp_modrm_byte,
   output logic [7:0]         rsp_sib_byte,
   output logic signed [31:0] rsp_displacement,
   output logic [2:0]         rsp_disp_bytes,
   output logic [63:0]        rsp_immediate,
   output logic [3:0]         rsp_imm_bytes
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic                   obuf_ready;
   logic                   take;
   logic                   res_valid;
   x86ifd_pkg::result_type res;
   x86ifd_pkg::result_type out_data;

   assign take      = in_valid_ff & obuf_ready;
   assign req_stall = in_valid_ff & ~obuf_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_code_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   x86ifd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (take),
      .step_byte  (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   x86ifd_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .push_ready (obuf_ready),
      .out_valid  (rsp_valid),
      .out_data   (out_data),
      .out_stall  (rsp_stall)
   );

   assign rsp_inst_length  = out_data.inst_length;
   assign rsp_rex_byte     = out_data.rex_byte;
   assign rsp_opcode       = out_data.opcode;
   assign rsp_modrm_byte   = out_data.modrm_byte;
   assign rsp_sib_byte     = out_data.sib_byte;
   assign rsp_displacement = out_data.displacement;
   assign rsp_disp_bytes   = out_data.disp_bytes;
   assign rsp_immediate    = out_data.immediate;
   assign rsp_imm_bytes    = out_data.imm_bytes;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && !obuf_ready))
      else $error("input stalled without a full result buffer");

   a_pending_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !take) |=> (in_valid_ff && in_byte_ff == $past(in_byte_ff)))
      else $error("pending code byte lost");

   a_result_only_on_take: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> take)
      else $error("result without a consumed byte");
`endif

endmodule

// ===== hw/rtl/x86ifd_core.sv =====
module x86ifd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_valid,
   input  logic [7:0]              step_byte,
   output logic                    res_valid,
   output x86ifd_pkg::result_type  res
);

   x86ifd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  rex_ff, rex_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [7:0]  sib_ff, sib_in;
   logic [31:0] disp_ff, disp_in;
   logic [2:0]  disp_size_ff, disp_size_in;
   logic [63:0] imm_ff, imm_in;
   logic [3:0]  imm_size_ff, imm_size_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [3:0]  count_ff, count_in;

   // working copy of the state after this byte, before the post-emit clear
   x86ifd_pkg::phase_type ph_n;
   logic [7:0]  rex_n, op_n, modrm_n, sib_n;
   logic [31:0] disp_n;
   logic [2:0]  dsz_n;
   logic [63:0] imm_n;
   logic [3:0]  isz_n;
   logic [3:0]  fbc_n, cnt_n;
   logic        emit;
   logic [1:0]  mod_f;
   logic [2:0]  rm_f;
   logic [7:0]  opc;

   always_comb begin
      ph_n    = phase_ff;
      rex_n   = rex_ff;
      op_n    = opcode_ff;
      modrm_n = modrm_ff;
      sib_n   = sib_ff;
      disp_n  = disp_ff;
      dsz_n   = disp_size_ff;
      imm_n   = imm_ff;
      isz_n   = imm_size_ff;
      fbc_n   = fbc_ff;
      cnt_n   = count_ff + 4'd1;
      emit    = 1'b0;
      mod_f   = step_byte[7:6];
      rm_f    = step_byte[2:0];
      opc     = step_byte;

      unique case (phase_ff)
         x86ifd_pkg::PH_MODRM: begin
            modrm_n = step_byte;
            if (mod_f != x86ifd_pkg::MOD_REGISTER && rm_f == x86ifd_pkg::RM_SIB) begin
               ph_n = x86ifd_pkg::PH_SIB;
            end else if (mod_f == x86ifd_pkg::MOD_DISP8) begin
               dsz_n = x86ifd_pkg::DISP_SIZE8;
               fbc_n = 4'd0;
               ph_n  = x86ifd_pkg::PH_DISP;
            end else if (mod_f == x86ifd_pkg::MOD_DISP32 ||
                         (mod_f == x86ifd_pkg::MOD_INDIRECT &&
                          rm_f == x86ifd_pkg::RM_DISP_ONLY)) begin
               dsz_n = x86ifd_pkg::DISP_SIZE32;
               fbc_n = 4'd0;
               ph_n  = x86ifd_pkg::PH_DISP;
            end else begin
               emit = 1'b1;
            end
         end
         x86ifd_pkg::PH_SIB: begin
            sib_n = step_byte;
            mod_f = modrm_ff[7:6];
            if (mod_f == x86ifd_pkg::MOD_DISP8) begin
               dsz_n = x86ifd_pkg::DISP_SIZE8;
               fbc_n = 4'd0;
               ph_n  = x86ifd_pkg::PH_DISP;
            end else if (mod_f == x86ifd_pkg::MOD_DISP32 ||
                         (mod_f == x86ifd_pkg::MOD_INDIRECT &&
                          rm_f == x86ifd_pkg::RM_DISP_ONLY)) begin
               dsz_n = x86ifd_pkg::DISP_SIZE32;
               fbc_n = 4'd0;
               ph_n  = x86ifd_pkg::PH_DISP;
            end else begin
               emit = 1'b1;
            end
         end
         x86ifd_pkg::PH_DISP: begin
            if (disp_size_ff == x86ifd_pkg::DISP_SIZE8) begin
               disp_n = {{24{step_byte[7]}}, step_byte};
               emit   = 1'b1;
            end else begin
               disp_n[{fbc_ff[1:0], 3'b000} +: 8] = disp_ff[{fbc_ff[1:0], 3'b000} +: 8]
                                                    | step_byte;
               fbc_n = fbc_ff + 4'd1;
               emit  = ({1'b0, fbc_n} >= {2'b00, disp_size_ff});
            end
         end
         x86ifd_pkg::PH_IMM: begin
            imm_n[{fbc_ff[2:0], 3'b000} +: 8] = imm_ff[{fbc_ff[2:0], 3'b000} +: 8]
                                                | step_byte;
            fbc_n = fbc_ff + 4'd1;
            emit  = (fbc_n >= imm_size_ff);
         end
         default: begin
            // start or opcode phase; a REX byte only counts as prefix at start
            if (phase_ff != x86ifd_pkg::PH_OPCODE &&
                (step_byte & x86ifd_pkg::REX_MASK) == x86ifd_pkg::REX_PATTERN) begin
               rex_n = step_byte;
               ph_n  = x86ifd_pkg::PH_OPCODE;
            end else begin
               op_n = opc;
               if (opc == x86ifd_pkg::OP_MOV_LOAD || opc == x86ifd_pkg::OP_MOV_STORE ||
                   opc == x86ifd_pkg::OP_ADD_STORE) begin
                  ph_n = x86ifd_pkg::PH_MODRM;
               end else if ((opc & x86ifd_pkg::OP_IMM_MASK) == x86ifd_pkg::OP_MOV_IMM) begin
                  isz_n = rex_n[x86ifd_pkg::REX_W_BIT] ? x86ifd_pkg::IMM_SIZE64
                                                       : x86ifd_pkg::IMM_SIZE32;
                  fbc_n = 4'd0;
                  ph_n  = x86ifd_pkg::PH_IMM;
               end else begin
                  emit = 1'b1;
               end
            end
         end
      endcase
   end

   assign res_valid        = step_valid & emit;
   assign res.inst_length  = cnt_n;
   assign res.rex_byte     = rex_n;
   assign res.opcode       = op_n;
   assign res.modrm_byte   = modrm_n;
   assign res.sib_byte     = sib_n;
   assign res.displacement = disp_n;
   assign res.disp_bytes   = dsz_n;
   assign res.immediate    = imm_n;
   assign res.imm_bytes    = isz_n;

   always_comb begin
      phase_in     = phase_ff;
      rex_in       = rex_ff;
      opcode_in    = opcode_ff;
      modrm_in     = modrm_ff;
      sib_in       = sib_ff;
      disp_in      = disp_ff;
      disp_size_in = disp_size_ff;
      imm_in       = imm_ff;
      imm_size_in  = imm_size_ff;
      fbc_in       = fbc_ff;
      count_in     = count_ff;
      if (step_valid && emit) begin
         phase_in     = x86ifd_pkg::PH_START;
         rex_in       = 8'd0;
         opcode_in    = 8'd0;
         modrm_in     = 8'd0;
         sib_in       = 8'd0;
         disp_in      = 32'd0;
         disp_size_in = x86ifd_pkg::DISP_NONE;
         imm_in       = 64'd0;
         imm_size_in  = x86ifd_pkg::IMM_NONE;
         fbc_in       = 4'd0;
         count_in     = 4'd0;
      end else if (step_valid) begin
         phase_in     = ph_n;
         rex_in       = rex_n;
         opcode_in    = op_n;
         modrm_in     = modrm_n;
         sib_in       = sib_n;
         disp_in      = disp_n;
         disp_size_in = dsz_n;
         imm_in       = imm_n;
         imm_size_in  = isz_n;
         fbc_in       = fbc_n;
         count_in     = cnt_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= x86ifd_pkg::PH_START;
         rex_ff       <= 8'd0;
         opcode_ff    <= 8'd0;
         modrm_ff     <= 8'd0;
         sib_ff       <= 8'd0;
         disp_ff      <= 32'd0;
         disp_size_ff <= x86ifd_pkg::DISP_NONE;
         imm_ff       <= 64'd0;
         imm_size_ff  <= x86ifd_pkg::IMM_NONE;
         fbc_ff       <= 4'd0;
         count_ff     <= 4'd0;
      end else begin
         phase_ff     <= phase_in;
         rex_ff       <= rex_in;
         opcode_ff    <= opcode_in;
         modrm_ff     <= modrm_in;
         sib_ff       <= sib_in;
         disp_ff      <= disp_in;
         disp_size_ff <= disp_size_in;
         imm_ff       <= imm_in;
         imm_size_ff  <= imm_size_in;
         fbc_ff       <= fbc_in;
         count_ff     <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (count_ff == 4'd0 && phase_ff == x86ifd_pkg::PH_START))
      else $error("state not cleared after result");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res.inst_length >= 4'd1 && res.inst_length <= 4'd10))
      else $error("instruction length out of range");

   a_disp_size: assert property (@(posedge clock) disable iff (reset)
      phase_ff == x86ifd_pkg::PH_DISP |->
         (disp_size_ff == x86ifd_pkg::DISP_SIZE8 || disp_size_ff == x86ifd_pkg::DISP_SIZE32))
      else $error("bad displacement size in displacement phase");

   a_imm_size: assert property (@(posedge clock) disable iff (reset)
      phase_ff == x86ifd_pkg::PH_IMM |->
         (imm_size_ff == x86ifd_pkg::IMM_SIZE32 || imm_size_ff == x86ifd_pkg::IMM_SIZE64))
      else $error("bad immediate size in immediate phase");
`endif

endmodule

// ===== hw/rtl/x86ifd_obuf.sv =====
module x86ifd_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  x86ifd_pkg::result_type  push_data,
   output logic                    push_ready,
   output logic                    out_valid,
   output x86ifd_pkg::result_type  out_data,
   input  logic                    out_stall
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   x86ifd_pkg::result_type main_ff, main_in;
   x86ifd_pkg::result_type skid_ff, skid_in;
   logic                   pop;

   assign pop        = main_valid_ff & ~out_stall;
   assign push_ready = ~skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push_valid;
         end
      end else if (push_valid) begin
         // output beat is stalled: park the new result
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_valid)
      else $error("result pushed while buffer full");

   a_stalled_hold: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && out_stall) |=> (main_valid_ff && main_ff == $past(main_ff)))
      else $error("stalled output changed");
`endif

endmodule

// ===== tb/x86ifd_checker.sv =====
`timescale 1ns / 100ps
module x86ifd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_code_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [3:0]         rsp_inst_length,
   input  logic [7:0]         rsp_rex_byte,
   input  logic [7:0]         rsp_opcode,
   input  logic [7:0]         rsp_modrm_byte,
   input  logic [7:0]         rsp_sib_byte,
   input  logic signed [31:0] rsp_displacement,
   input  logic [2:0]         rsp_disp_bytes,
   input  logic [63:0]        rsp_immediate,
   input  logic [3:0]         rsp_imm_bytes,
   output int                 mismatches,
   output int                 pending
);

   // decode state mirrored from the byte stream
   x86ifd_pkg::phase_type ph;
   logic [7:0]  rex_h;
   logic [7:0]  op_h;
   logic [7:0]  modrm_h;
   logic [7:0]  sib_h;
   logic [31:0] disp_h;
   logic [2:0]  dsize_h;
   logic [63:0] imm_h;
   logic [3:0]  isize_h;
   logic [3:0]  cnt_h;
   logic [3:0]  seen_h;

   x86ifd_pkg::result_type expected_insts[$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function void restart_decode();
      ph = x86ifd_pkg::PH_START;
      rex_h = '0;
      op_h = '0;
      modrm_h = '0;
      sib_h = '0;
      disp_h = '0;
      dsize_h = x86ifd_pkg::DISP_NONE;
      imm_h = '0;
      isize_h = x86ifd_pkg::IMM_NONE;
      cnt_h = '0;
      seen_h = '0;
   endfunction

   function void close_inst();
      x86ifd_pkg::result_type r;
      r.inst_length = seen_h;
      r.rex_byte = rex_h;
      r.opcode = op_h;
      r.modrm_byte = modrm_h;
      r.sib_byte = sib_h;
      r.displacement = disp_h;
      r.disp_bytes = dsize_h;
      r.immediate = imm_h;
      r.imm_bytes = isize_h;
      expected_insts.push_back(r);
      restart_decode();
   endfunction

   function void disp_or_close(logic [2:0] size);
      if (size == x86ifd_pkg::DISP_NONE) begin
         close_inst();
      end else begin
         dsize_h = size;
         cnt_h = '0;
         ph = x86ifd_pkg::PH_DISP;
      end
   endfunction

   function void opcode_taken(logic [7:0] b);
      op_h = b;
      if (b == x86ifd_pkg::OP_MOV_LOAD || b == x86ifd_pkg::OP_MOV_STORE ||
          b == x86ifd_pkg::OP_ADD_STORE) begin
         ph = x86ifd_pkg::PH_MODRM;
      end else if ((b & x86ifd_pkg::OP_IMM_MASK) == x86ifd_pkg::OP_MOV_IMM) begin
         isize_h = rex_h[x86ifd_pkg::REX_W_BIT] ? x86ifd_pkg::IMM_SIZE64
                                                : x86ifd_pkg::IMM_SIZE32;
         cnt_h = '0;
         ph = x86ifd_pkg::PH_IMM;
      end else begin
         close_inst();
      end
   endfunction

   function void decode_byte(logic [7:0] b);
      logic [1:0] md;
      logic [2:0] rm;
      md = b[7:6];
      rm = b[2:0];
      seen_h = seen_h + 4'd1;
      case (ph)
         x86ifd_pkg::PH_START: begin
            if ((b & x86ifd_pkg::REX_MASK) == x86ifd_pkg::REX_PATTERN) begin
               rex_h = b;
               ph = x86ifd_pkg::PH_OPCODE;
            end else begin
               opcode_taken(b);
            end
         end
         x86ifd_pkg::PH_OPCODE: begin
            // anything after a REX is the opcode, even another REX value
            opcode_taken(b);
         end
         x86ifd_pkg::PH_MODRM: begin
            modrm_h = b;
            if (md != x86ifd_pkg::MOD_REGISTER && rm == x86ifd_pkg::RM_SIB)
               ph = x86ifd_pkg::PH_SIB;
            else if (md == x86ifd_pkg::MOD_DISP8)
               disp_or_close(x86ifd_pkg::DISP_SIZE8);
            else if (md == x86ifd_pkg::MOD_DISP32 ||
                     (md == x86ifd_pkg::MOD_INDIRECT && rm == x86ifd_pkg::RM_DISP_ONLY))
               disp_or_close(x86ifd_pkg::DISP_SIZE32);
            else
               close_inst();
         end
         x86ifd_pkg::PH_SIB: begin
            sib_h = b;
            md = modrm_h[7:6];
            if (md == x86ifd_pkg::MOD_DISP8)
               disp_or_close(x86ifd_pkg::DISP_SIZE8);
            else if (md == x86ifd_pkg::MOD_DISP32 ||
                     (md == x86ifd_pkg::MOD_INDIRECT && rm == x86ifd_pkg::RM_DISP_ONLY))
               disp_or_close(x86ifd_pkg::DISP_SIZE32);
            else
               close_inst();
         end
         x86ifd_pkg::PH_DISP: begin
            if (dsize_h == x86ifd_pkg::DISP_SIZE8) begin
               disp_h = {{24{b[7]}}, b};
               close_inst();
            end else begin
               disp_h = disp_h | (32'(b) << (8 * cnt_h[1:0]));
               cnt_h = cnt_h + 4'd1;
               if (cnt_h >= 4'(dsize_h))
                  close_inst();
            end
         end
         x86ifd_pkg::PH_IMM: begin
            imm_h = imm_h | (64'(b) << (8 * cnt_h[2:0]));
            cnt_h = cnt_h + 4'd1;
            if (cnt_h >= isize_h)
               close_inst();
         end
         default: begin
            restart_decode();
         end
      endcase
   endfunction

   function void show(string tag, x86ifd_pkg::result_type r);
      $display("  %s len=%0d rex=%h op=%h modrm=%h sib=%h disp=%h/%0d imm=%h/%0d", tag,
               r.inst_length, r.rex_byte, r.opcode, r.modrm_byte, r.sib_byte,
               r.displacement, r.disp_bytes, r.immediate, r.imm_bytes);
   endfunction

   always @(posedge clock) begin : watch
      x86ifd_pkg::result_type want;
      x86ifd_pkg::result_type got;
      if (reset) begin
         restart_decode();
         expected_insts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.inst_length = rsp_inst_length;
            got.rex_byte = rsp_rex_byte;
            got.opcode = rsp_opcode;
            got.modrm_byte = rsp_modrm_byte;
            got.sib_byte = rsp_sib_byte;
            got.displacement = rsp_displacement;
            got.disp_bytes = rsp_disp_bytes;
            got.immediate = rsp_immediate;
            got.imm_bytes = rsp_imm_bytes;
            if (expected_insts.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("ERROR: result beat with no instruction pending");
                  show("got", got);
               end
            end else begin
               want = expected_insts.pop_front();
               if (got.inst_length !== want.inst_length || got.rex_byte !== want.rex_byte ||
                   got.opcode !== want.opcode || got.modrm_byte !== want.modrm_byte ||
                   got.sib_byte !== want.sib_byte ||
                   got.displacement !== want.displacement ||
                   got.disp_bytes !== want.disp_bytes || got.immediate !== want.immediate ||
                   got.imm_bytes !== want.imm_bytes) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("ERROR: decoded fields differ");
                     show("exp", want);
                     show("got", got);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            decode_byte(req_code_byte);
      end
      pending <= expected_insts.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_code_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_inst_length;
   logic [7:0]         rsp_rex_byte;
   logic [7:0]         rsp_opcode;
   logic [7:0]         rsp_modrm_byte;
   logic [7:0]         rsp_sib_byte;
   logic signed [31:0] rsp_displacement;
   logic [2:0]         rsp_disp_bytes;
   logic [63:0]        rsp_immediate;
   logic [3:0]         rsp_imm_bytes;

   int mismatches;
   int pending;
   int cyc = 0;
   logic [7:0] code_stream[$];

   x86_64_instruction_field_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inst_length  (rsp_inst_length),
      .rsp_rex_byte     (rsp_rex_byte),
      .rsp_opcode       (rsp_opcode),
      .rsp_modrm_byte   (rsp_modrm_byte),
      .rsp_sib_byte     (rsp_sib_byte),
      .rsp_displacement (rsp_displacement),
      .rsp_disp_bytes   (rsp_disp_bytes),
      .rsp_immediate    (rsp_immediate),
      .rsp_imm_bytes    (rsp_imm_bytes)
   );

   x86ifd_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inst_length  (rsp_inst_length),
      .rsp_rex_byte     (rsp_rex_byte),
      .rsp_opcode       (rsp_opcode),
      .rsp_modrm_byte   (rsp_modrm_byte),
      .rsp_sib_byte     (rsp_sib_byte),
      .rsp_displacement (rsp_displacement),
      .rsp_disp_bytes   (rsp_disp_bytes),
      .rsp_immediate    (rsp_immediate),
      .rsp_imm_bytes    (rsp_imm_bytes),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cyc <= cyc + 1;

   // no idling on either side inside this window
   function automatic bit idle_now();
      return (cyc < 150 || cyc >= 450) && ($urandom_range(99) < 24);
   endfunction

   function automatic void put_rex_maybe(output logic [7:0] rex);
      rex = '0;
      if ($urandom_range(1)) begin
         rex = x86ifd_pkg::REX_PATTERN | 8'($urandom_range(15));
         code_stream.push_back(rex);
      end
   endfunction

   function automatic void put_mem_inst();
      logic [7:0] rex;
      logic [7:0] modrm;
      logic [7:0] sib;
      int nd;
      put_rex_maybe(rex);
      case ($urandom_range(2))
         0:       code_stream.push_back(x86ifd_pkg::OP_MOV_LOAD);
         1:       code_stream.push_back(x86ifd_pkg::OP_MOV_STORE);
         default: code_stream.push_back(x86ifd_pkg::OP_ADD_STORE);
      endcase
      modrm = 8'($urandom_range(255));
      if ($urandom_range(3) == 0)
         modrm[2:0] = x86ifd_pkg::RM_SIB;
      code_stream.push_back(modrm);
      nd = 0;
      if (modrm[7:6] != x86ifd_pkg::MOD_REGISTER && modrm[2:0] == x86ifd_pkg::RM_SIB) begin
         sib = 8'($urandom_range(255));
         if ($urandom_range(3) == 0)
            sib[2:0] = x86ifd_pkg::RM_DISP_ONLY;
         code_stream.push_back(sib);
         if (modrm[7:6] == x86ifd_pkg::MOD_DISP8)
            nd = 1;
         else if (modrm[7:6] == x86ifd_pkg::MOD_DISP32 ||
                  (modrm[7:6] == x86ifd_pkg::MOD_INDIRECT &&
                   sib[2:0] == x86ifd_pkg::RM_DISP_ONLY))
            nd = 4;
      end else if (modrm[7:6] == x86ifd_pkg::MOD_DISP8) begin
         nd = 1;
      end else if (modrm[7:6] == x86ifd_pkg::MOD_DISP32 ||
                   (modrm[7:6] == x86ifd_pkg::MOD_INDIRECT &&
                    modrm[2:0] == x86ifd_pkg::RM_DISP_ONLY)) begin
         nd = 4;
      end
      repeat (nd) code_stream.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void put_imm_inst();
      logic [7:0] rex;
      put_rex_maybe(rex);
      code_stream.push_back(x86ifd_pkg::OP_MOV_IMM | 8'($urandom_range(7)));
      repeat (rex[x86ifd_pkg::REX_W_BIT] ? 8 : 4)
         code_stream.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void build_stream();
      logic [7:0] opening[28] = '{
         8'h00,
         8'h4F, 8'h4F,
         x86ifd_pkg::REX_PATTERN | 8'h08, x86ifd_pkg::OP_MOV_IMM,
         8'h01, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'hAA, 8'h55, 8'hFE,
         x86ifd_pkg::OP_MOV_LOAD, 8'hC0,
         x86ifd_pkg::OP_MOV_STORE, 8'h05, 8'h78, 8'h56, 8'h34, 8'h92,
         x86ifd_pkg::OP_MOV_LOAD, 8'h04, 8'h25, 8'hEF, 8'hBE, 8'hAD, 8'hDE
      };
      logic [7:0] rex;
      int pick;
      foreach (opening[i]) code_stream.push_back(opening[i]);
      while (code_stream.size() < 1028) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // raw noise, may leave the decoder mid-instruction
            repeat ($urandom_range(6, 1)) code_stream.push_back(8'($urandom_range(255)));
         end else if (pick < 22) begin
            put_rex_maybe(rex);
            code_stream.push_back(8'($urandom_range(255)));
         end else if (pick < 65) begin
            put_mem_inst();
         end else begin
            put_imm_inst();
         end
      end
   endfunction

   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (cyc == 600) begin
            // long hold-off so the result buffer fills and backs up the input
            rsp_stall <= 1'b1;
            repeat (160) @(negedge clock);
         end
         rsp_stall <= idle_now();
      end
   end

   initial begin : stimulus
      int idx;
      bit took;
      bit paused;
      reset = 1;
      req_valid = 0;
      req_code_byte = '0;
      idx = 0;
      paused = 0;
      build_stream();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (idx < code_stream.size()) begin
         @(posedge clock);
         took = req_valid && !req_stall;
         if (took)
            idx = idx + 1;
         @(negedge clock);
         if (req_valid && !took)
            continue;
         if (idx == 28 && !paused) begin
            // drain everything after the directed beats before going on
            paused = 1;
            req_valid <= 1'b0;
            while (pending != 0) @(negedge clock);
            continue;
         end
         if (idx < code_stream.size() && !idle_now()) begin
            req_valid <= 1'b1;
            req_code_byte <= code_stream[idx];
         end else begin
            req_valid <= 1'b0;
         end
      end
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #300000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
